### design/oidber_pkg.sv
// Shared types and constants for the OID BER subidentifier decoder.
// No dependencies; every other design file refers to this package by scope.
`timescale 1ns / 1ps

package oidber_pkg;

  localparam int unsigned ARC_OUT_W    = 32;
  localparam int unsigned GROUP_W      = 7;
  localparam int unsigned CONT_BIT     = 7;
  localparam int unsigned FIRST_DIVISOR = 40;
  // byte / 40 == (byte * 205) >> 13 for every 8-bit byte
  localparam int unsigned DIV40_MUL    = 205;
  localparam int unsigned DIV40_SHIFT  = 13;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_TRUNCATED = 2'd2
  } err_t;

  typedef struct packed {
    logic [ARC_OUT_W-1:0] arc_value;
    logic                 run_last;
    logic                 oid_done;
    err_t                 error_code;
  } result_t;

endpackage

### design/oidber_if.sv
// Valid/ready channel interfaces for the OID BER decoder: input bytes and result arcs.
// Depends on oidber_pkg for the arc_value width.
`timescale 1ns / 1ps

interface oidber_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       final_byte;

  modport source (output valid, data_byte, first_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, final_byte, output ready);
endinterface

interface oidber_out_if;
  logic                            valid;
  logic                            ready;
  logic [oidber_pkg::ARC_OUT_W-1:0] arc_value;
  logic                            run_last;
  logic                            oid_done;
  logic [1:0]                      error_code;

  modport source (output valid, arc_value, run_last, oid_done, error_code, input ready);
  modport sink   (input valid, arc_value, run_last, oid_done, error_code, output ready);
endinterface

### design/oidber_first_split.sv
// Splits the first content byte into byte / 40 and byte % 40.
// Reciprocal multiply, no divider; constants from oidber_pkg.
`timescale 1ns / 1ps

module oidber_first_split (
  input  logic [7:0] data_byte,
  output logic [2:0] quo,
  output logic [5:0] rem
);

  logic [15:0] prod;
  logic [7:0]  quo_times_div;
  logic [7:0]  diff;

  assign prod          = 16'(data_byte) * 16'(oidber_pkg::DIV40_MUL);
  assign quo           = prod[15:oidber_pkg::DIV40_SHIFT];
  assign quo_times_div = 8'(quo) * 8'(oidber_pkg::FIRST_DIVISOR);
  assign diff          = data_byte - quo_times_div;
  assign rem           = diff[5:0];

endmodule

### design/oid_ber_subidentifier_decoder.sv
// OID BER subidentifier decoder: one content byte per beat in, arcs out.
// A result is offered in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output accepts results; a first byte yields two beats and
// holds the input off while the first of them drains from the result buffer.
// Reset (rst, synchronous): accumulator and flags cleared, result buffer emptied.
// Depends on oidber_pkg, oidber_if and oidber_first_split.
`timescale 1ns / 1ps

module oid_ber_subidentifier_decoder #(
  parameter int unsigned ARC_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  oidber_in_if.sink           in_ch,
  oidber_out_if.source        out_ch
);

  localparam int unsigned GW = oidber_pkg::GROUP_W;

  // arc state
  logic [ARC_WIDTH-1:0] arc_accumulator, arc_accumulator_next;
  logic                 arc_in_progress, arc_in_progress_next;
  logic                 overflow_seen, overflow_seen_next;

  // two-entry result buffer, slot0 is the head
  oidber_pkg::result_t slot0, slot0_next;
  oidber_pkg::result_t slot1, slot1_next;
  logic [1:0]          count, count_next;

  logic                in_fire, out_fire;
  logic [2:0]          first_quo;
  logic [5:0]          first_rem;
  logic [ARC_WIDTH-1:0] shifted;
  logic                 ovf_now;
  logic [ARC_WIDTH+oidber_pkg::ARC_OUT_W-1:0] arc_wide;
  oidber_pkg::result_t res0, res1;
  logic [1:0]          res_count;

  oidber_first_split u_split (
    .data_byte (in_ch.data_byte),
    .quo       (first_quo),
    .rem       (first_rem)
  );

  assign out_fire    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (count == 2'd0) || ((count == 2'd1) && out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign ovf_now  = |arc_accumulator[ARC_WIDTH-1 -: GW];
  assign shifted  = {arc_accumulator[ARC_WIDTH-GW-1:0], in_ch.data_byte[GW-1:0]};
  assign arc_wide = {{oidber_pkg::ARC_OUT_W{1'b0}}, shifted};

  // per-byte decode and state update
  always_comb begin
    arc_accumulator_next = arc_accumulator;
    arc_in_progress_next = arc_in_progress;
    overflow_seen_next   = overflow_seen;
    res0                 = '0;
    res1                 = '0;
    res_count            = 2'd0;
    if (in_fire) begin
      if (in_ch.first_byte) begin
        arc_accumulator_next = '0;
        arc_in_progress_next = 1'b0;
        overflow_seen_next   = 1'b0;
        res0.arc_value       = oidber_pkg::ARC_OUT_W'(first_quo);
        res0.error_code      = oidber_pkg::ERR_OK;
        res1.arc_value       = oidber_pkg::ARC_OUT_W'(first_rem);
        res1.run_last        = 1'b1;
        res1.oid_done        = in_ch.final_byte;
        res1.error_code      = oidber_pkg::ERR_OK;
        res_count            = 2'd2;
      end else if (!in_ch.data_byte[oidber_pkg::CONT_BIT]) begin
        res0.arc_value       = arc_wide[oidber_pkg::ARC_OUT_W-1:0];
        res0.run_last        = 1'b1;
        res0.oid_done        = in_ch.final_byte;
        res0.error_code      = (overflow_seen || ovf_now) ? oidber_pkg::ERR_OVERFLOW
                                                          : oidber_pkg::ERR_OK;
        res_count            = 2'd1;
        arc_accumulator_next = '0;
        arc_in_progress_next = 1'b0;
        overflow_seen_next   = 1'b0;
      end else if (in_ch.final_byte) begin
        // truncated: wins over overflow
        res0.arc_value       = arc_wide[oidber_pkg::ARC_OUT_W-1:0];
        res0.run_last        = 1'b1;
        res0.oid_done        = 1'b1;
        res0.error_code      = oidber_pkg::ERR_TRUNCATED;
        res_count            = 2'd1;
        arc_accumulator_next = '0;
        arc_in_progress_next = 1'b0;
        overflow_seen_next   = 1'b0;
      end else begin
        arc_accumulator_next = shifted;
        arc_in_progress_next = 1'b1;
        overflow_seen_next   = overflow_seen || ovf_now;
      end
    end
  end

  // buffer: a push only happens when the buffer is empty after this cycle's pop
  always_comb begin
    slot0_next = slot0;
    slot1_next = slot1;
    count_next = count;
    if (in_fire) begin
      slot0_next = res0;
      slot1_next = res1;
      count_next = res_count;
    end else if (out_fire) begin
      slot0_next = slot1;
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arc_accumulator <= '0;
      arc_in_progress <= 1'b0;
      overflow_seen   <= 1'b0;
      count           <= 2'd0;
    end else begin
      arc_accumulator <= arc_accumulator_next;
      arc_in_progress <= arc_in_progress_next;
      overflow_seen   <= overflow_seen_next;
      count           <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  assign out_ch.valid      = (count != 2'd0);
  assign out_ch.arc_value  = slot0.arc_value;
  assign out_ch.run_last   = slot0.run_last;
  assign out_ch.oid_done   = slot0.oid_done;
  assign out_ch.error_code = slot0.error_code;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_idle_arc_clear: assert property (@(posedge clk) disable iff (rst)
    !arc_in_progress |-> (arc_accumulator == '0) && !overflow_seen)
    else $error("accumulator not clear between arcs");

  a_first_two_beats: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.first_byte) |=> out_ch.valid && !out_ch.run_last && (count == 2'd2))
    else $error("first byte did not queue two beats");

  a_trunc_done: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.error_code == oidber_pkg::ERR_TRUNCATED))
      |-> out_ch.oid_done && out_ch.run_last)
    else $error("truncated arc without done");

endmodule
